### design/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg: shared types, constants and helpers for the line rasterizer
// Grid geometry, controller states and the control/status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int GRID_SIZE = 64;
  localparam int COORD_W   = 6;
  localparam int COLOR_W   = 32;

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_EMIT
  } lr_state_e;

  typedef struct packed {
    logic load;   // capture a new segment
    logic setup;  // derive axes, span and slope terms
    logic step;   // advance to the next pixel
  } lr_cmd_t;

  typedef struct packed {
    logic last;   // current pixel closes the segment
  } lr_status_t;

  // Saturate a coordinate to the grid.
  function automatic coord_t clamp_coord(input coord_t c);
    coord_t res;
    res = c;
    if ({1'b0, c} >= (COORD_W + 1)'(GRID_SIZE)) begin
      res = COORD_W'(GRID_SIZE - 1);
    end
    return res;
  endfunction

endpackage

### design/line_rasterizer.sv
// ----------------------------------------------------------------------------
// line_rasterizer: interpolated DDA line rasterization on a square grid
// First pixel is valid after a segment transfer once the setup state has
// run. A segment of major span S then streams S+1 pixels, one per output
// cycle while out_ready_i is high; no new segment is taken until the last
// pixel has transferred.
// Reset returns the controller to idle; segment registers are not reset.
// ----------------------------------------------------------------------------
module line_rasterizer
  import lr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  coord_t             start_x_i,
  input  coord_t             start_y_i,
  input  coord_t             end_x_i,
  input  coord_t             end_y_i,
  input  logic [COLOR_W-1:0] color_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output coord_t             pixel_x_o,
  output coord_t             pixel_y_o,
  output logic [COLOR_W-1:0] pixel_color_o,
  output logic               last_o
);

  lr_cmd_t    cmd;
  lr_status_t status;

  lr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lr_datapath u_datapath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .color_i       (color_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_o        (last_o)
  );

  // no new segment while pixels are pending
  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while pixels pending");

  // setup cycle separates capture and first pixel
  a_setup_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!out_valid_o && !in_ready_o && !cmd.step))
    else $error("pixel or input right after segment transfer");

  // pixels keep coming until the last one
  a_stream_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> out_valid_o)
    else $error("segment stream broke before last pixel");

  // last pixel transfer frees the block
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> (in_ready_o && !out_valid_o))
    else $error("block not idle after last pixel");

endmodule

### design/lr_ctrl.sv
// ----------------------------------------------------------------------------
// lr_ctrl: sequencing of the line rasterizer
// Takes a segment, spends a setup state, then walks its pixels one per
// output transfer until the last one is taken.
// ----------------------------------------------------------------------------
module lr_ctrl
  import lr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  lr_status_t status_i,
  output lr_cmd_t    cmd_o
);

  lr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready_i && status_i.last) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        cmd_o.step  = out_ready_i && !status_i.last;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### design/lr_datapath.sv
// ----------------------------------------------------------------------------
// lr_datapath: segment registers and incremental interpolation
// Keeps the minor coordinate as quotient and remainder of the exact
// interpolation and updates both with one add and compare per pixel.
// ----------------------------------------------------------------------------
module lr_datapath
  import lr_pkg::*;
(
  input  logic               clk_i,
  input  lr_cmd_t            cmd_i,
  output lr_status_t         status_o,
  input  coord_t             start_x_i,
  input  coord_t             start_y_i,
  input  coord_t             end_x_i,
  input  coord_t             end_y_i,
  input  logic [COLOR_W-1:0] color_i,
  output coord_t             pixel_x_o,
  output coord_t             pixel_y_o,
  output logic [COLOR_W-1:0] pixel_color_o,
  output logic               last_o
);

  coord_t             ax_q, ay_q, bx_q, by_q;
  logic [COLOR_W-1:0] color_q;
  logic               steep_q, dneg_q;
  coord_t             m_q, m1_q, span_q, dabs_q, quo_q;
  logic [COORD_W:0]   rem_q;

  // Setup terms
  coord_t adx, ady, m0, n0, m1, n1, pm0, pn0, pm1, pn1;
  logic   steep;

  always_comb begin
    adx   = (ax_q > bx_q) ? ax_q - bx_q : bx_q - ax_q;
    ady   = (ay_q > by_q) ? ay_q - by_q : by_q - ay_q;
    steep = adx < ady;
    pm0   = steep ? ay_q : ax_q;
    pn0   = steep ? ax_q : ay_q;
    pm1   = steep ? by_q : bx_q;
    pn1   = steep ? bx_q : by_q;
    // order so the major coordinate runs upward
    if (pm0 > pm1) begin
      m0 = pm1; n0 = pn1; m1 = pm0; n1 = pn0;
    end else begin
      m0 = pm0; n0 = pn0; m1 = pm1; n1 = pn1;
    end
  end

  // Step terms: the slope magnitude never exceeds the span, so one
  // correction keeps the remainder in range.
  logic [COORD_W:0] span_ext, dabs_ext, rem_up, rem_dn, rem_next;
  logic             quo_inc, quo_dec;

  always_comb begin
    span_ext = {1'b0, span_q};
    dabs_ext = {1'b0, dabs_q};
    rem_up   = rem_q + dabs_ext;
    rem_dn   = rem_q + span_ext - dabs_ext;
    quo_inc  = 1'b0;
    quo_dec  = 1'b0;
    if (!dneg_q) begin
      if (rem_up >= span_ext) begin
        rem_next = rem_up - span_ext;
        quo_inc  = 1'b1;
      end else begin
        rem_next = rem_up;
      end
    end else begin
      if (rem_q >= dabs_ext) begin
        rem_next = rem_q - dabs_ext;
      end else begin
        rem_next = rem_dn;
        quo_dec  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q    <= clamp_coord(start_x_i);
      ay_q    <= clamp_coord(start_y_i);
      bx_q    <= clamp_coord(end_x_i);
      by_q    <= clamp_coord(end_y_i);
      color_q <= color_i;
    end
    if (cmd_i.setup) begin
      steep_q <= steep;
      m_q     <= m0;
      m1_q    <= m1;
      span_q  <= m1 - m0;
      dneg_q  <= n1 < n0;
      dabs_q  <= (n1 < n0) ? n0 - n1 : n1 - n0;
      quo_q   <= n0;
      rem_q   <= '0;
    end else if (cmd_i.step) begin
      m_q   <= m_q + 1'b1;
      rem_q <= rem_next;
      if (quo_inc) quo_q <= quo_q + 1'b1;
      else if (quo_dec) quo_q <= quo_q - 1'b1;
    end
  end

  assign status_o.last = (m_q == m1_q);
  assign pixel_x_o     = steep_q ? quo_q : m_q;
  assign pixel_y_o     = steep_q ? m_q : quo_q;
  assign pixel_color_o = color_q;
  assign last_o        = status_o.last;

endmodule
